### hw/rtl/mqttf_pkg.sv
`default_nettype none

package mqttf_pkg;

  // Longest run of bytes that one request can cause (connect header).
  localparam int unsigned RUN_MAX = 18;
  localparam int unsigned CNT_W   = 5;
  // Bytes after the remaining length field in a command run.
  localparam int unsigned TAIL_MAX = 14;
  localparam int unsigned TAIL_W   = 4;

  typedef enum logic [2:0] {
    REQ_CONNECT     = 3'd0,
    REQ_PUBLISH     = 3'd1,
    REQ_SUBSCRIBE   = 3'd2,
    REQ_UNSUBSCRIBE = 3'd3,
    REQ_DISCONNECT  = 3'd4,
    REQ_DATA        = 3'd5
  } req_e;

  typedef enum logic [4:0] {
    KIND_IDLE        = 5'b00001,
    KIND_CONNECT     = 5'b00010,
    KIND_PUBLISH     = 5'b00100,
    KIND_SUBSCRIBE   = 5'b01000,
    KIND_UNSUBSCRIBE = 5'b10000
  } kind_e;

  localparam logic [7:0] HDR_CONNECT     = 8'h10;
  localparam logic [7:0] HDR_PUBLISH     = 8'h30;
  localparam logic [7:0] HDR_SUBSCRIBE   = 8'h82;
  localparam logic [7:0] HDR_UNSUBSCRIBE = 8'hA2;
  localparam logic [7:0] HDR_DISCONNECT  = 8'hE0;

  localparam logic [7:0] FLAGS_CLEAN     = 8'h02;
  localparam logic [7:0] FLAG_USERNAME   = 8'h80;
  localparam logic [7:0] FLAG_PASSWORD   = 8'h40;
  localparam logic [7:0] PROTO_LEVEL     = 8'h04;
  localparam logic [15:0] PROTO_NAME_LEN = 16'd4;
  localparam logic [7:0] CHAR_M          = 8'h4D;
  localparam logic [7:0] CHAR_Q          = 8'h51;
  localparam logic [7:0] CHAR_T          = 8'h54;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic [15:0] first_len;
    logic [15:0] second_len;
    logic [15:0] third_len;
    logic [1:0]  req_qos;
    logic        retain_flag;
    logic [15:0] packet_ident;
    logic [15:0] keep_alive_secs;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;
    logic       seq_error;
  } res_t;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  section;
    logic [15:0] bytes_left;
    logic [15:0] held_second_len;
    logic [15:0] held_third_len;
    logic [1:0]  held_qos;
    logic [15:0] held_packet_ident;
  } state_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic                    pkt_end;
    logic                    err;
  } run_t;

endpackage

`default_nettype wire

### hw/rtl/mqttf_stream_if.sv
`default_nettype none

interface mqttf_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/mqttf_step.sv
`default_nettype none

// Next state and byte run for one request, given the current packet state.
module mqttf_step import mqttf_pkg::*; (
  input  state_t st_i,
  input  req_t   req_i,
  output state_t st_o,
  output run_t   run_o
);

  always_comb begin
    logic                     open_pkt;
    logic                     bad;
    logic                     is_cmd;
    logic [7:0]               hdr;
    logic [7:0]               flags;
    logic [17:0]              rl;
    logic [1:0]               rl_n;
    logic [2:0][7:0]          rl_b;
    logic [TAIL_MAX-1:0][7:0] tail;
    logic [TAIL_W-1:0]        tail_n;
    logic [15:0]              bl_dec;
    logic                     fin;

    open_pkt = (st_i.kind != KIND_IDLE);
    is_cmd   = (req_i.req_type <= REQ_DISCONNECT);
    bad      = (req_i.req_type > REQ_DATA) ||
               ((req_i.req_type == REQ_DATA) && !open_pkt) ||
               (is_cmd && open_pkt);

    hdr    = HDR_DISCONNECT;
    flags  = FLAGS_CLEAN;
    rl     = '0;
    rl_n   = 2'd1;
    rl_b   = '0;
    tail   = '0;
    tail_n = '0;
    bl_dec = st_i.bytes_left - 16'd1;
    fin    = 1'b0;

    st_o           = st_i;
    run_o.bytes    = '0;
    run_o.count    = CNT_W'(1);
    run_o.pkt_end  = 1'b0;
    run_o.err      = 1'b0;

    if (bad) begin
      run_o.err = 1'b1;
    end else if (is_cmd) begin
      st_o.held_second_len   = req_i.second_len;
      st_o.held_third_len    = req_i.third_len;
      st_o.held_qos          = req_i.req_qos;
      st_o.held_packet_ident = req_i.packet_ident;
      st_o.section           = 2'd0;
      st_o.bytes_left        = req_i.first_len;
      st_o.kind              = KIND_IDLE;

      case (req_i.req_type)
        REQ_CONNECT: begin
          hdr = HDR_CONNECT;
          if (req_i.second_len != 16'd0) flags = flags | FLAG_USERNAME;
          if (req_i.third_len != 16'd0)  flags = flags | FLAG_PASSWORD;
          rl = 18'd12 + 18'(req_i.first_len) +
               ((req_i.second_len != 16'd0) ? 18'(req_i.second_len) + 18'd2 : 18'd0) +
               ((req_i.third_len != 16'd0) ? 18'(req_i.third_len) + 18'd2 : 18'd0);
          tail[0]  = PROTO_NAME_LEN[15:8];
          tail[1]  = PROTO_NAME_LEN[7:0];
          tail[2]  = CHAR_M;
          tail[3]  = CHAR_Q;
          tail[4]  = CHAR_T;
          tail[5]  = CHAR_T;
          tail[6]  = PROTO_LEVEL;
          tail[7]  = flags;
          tail[8]  = req_i.keep_alive_secs[15:8];
          tail[9]  = req_i.keep_alive_secs[7:0];
          tail[10] = req_i.first_len[15:8];
          tail[11] = req_i.first_len[7:0];
          tail_n   = TAIL_W'(12);
          st_o.kind = KIND_CONNECT;
          // empty client id: skip to the first present credential
          if (req_i.first_len == 16'd0) begin
            if (req_i.second_len != 16'd0) begin
              tail[12] = req_i.second_len[15:8];
              tail[13] = req_i.second_len[7:0];
              tail_n   = TAIL_W'(14);
              st_o.section    = 2'd1;
              st_o.bytes_left = req_i.second_len;
            end else if (req_i.third_len != 16'd0) begin
              tail[12] = req_i.third_len[15:8];
              tail[13] = req_i.third_len[7:0];
              tail_n   = TAIL_W'(14);
              st_o.section    = 2'd2;
              st_o.bytes_left = req_i.third_len;
            end else begin
              fin = 1'b1;
            end
          end
        end
        REQ_PUBLISH: begin
          hdr = HDR_PUBLISH | {5'd0, req_i.req_qos, req_i.retain_flag};
          rl  = 18'd2 + 18'(req_i.first_len) + 18'(req_i.second_len) +
                ((req_i.req_qos != 2'd0) ? 18'd2 : 18'd0);
          tail[0] = req_i.first_len[15:8];
          tail[1] = req_i.first_len[7:0];
          tail_n  = TAIL_W'(2);
          st_o.kind = KIND_PUBLISH;
          if (req_i.first_len == 16'd0) begin
            if (req_i.req_qos != 2'd0) begin
              tail[2] = req_i.packet_ident[15:8];
              tail[3] = req_i.packet_ident[7:0];
              tail_n  = TAIL_W'(4);
            end
            if (req_i.second_len != 16'd0) begin
              st_o.section    = 2'd1;
              st_o.bytes_left = req_i.second_len;
            end else begin
              fin = 1'b1;
            end
          end
        end
        REQ_SUBSCRIBE, REQ_UNSUBSCRIBE: begin
          if (req_i.req_type == REQ_SUBSCRIBE) begin
            hdr       = HDR_SUBSCRIBE;
            rl        = 18'd5 + 18'(req_i.first_len);
            st_o.kind = KIND_SUBSCRIBE;
          end else begin
            hdr       = HDR_UNSUBSCRIBE;
            rl        = 18'd4 + 18'(req_i.first_len);
            st_o.kind = KIND_UNSUBSCRIBE;
          end
          tail[0] = req_i.packet_ident[15:8];
          tail[1] = req_i.packet_ident[7:0];
          tail[2] = req_i.first_len[15:8];
          tail[3] = req_i.first_len[7:0];
          tail_n  = TAIL_W'(4);
          if (req_i.first_len == 16'd0) begin
            fin = 1'b1;
            if (req_i.req_type == REQ_SUBSCRIBE) begin
              tail[4] = {6'd0, req_i.req_qos};
              tail_n  = TAIL_W'(5);
            end
          end
        end
        default: begin
          // disconnect: header and a zero remaining length
          fin = 1'b1;
        end
      endcase

      // remaining length, base-128 with continuation bit
      rl_b[0] = {(rl > 18'd127), rl[6:0]};
      rl_b[1] = {(rl > 18'd16383), rl[13:7]};
      rl_b[2] = {4'd0, rl[17:14]};
      if (rl > 18'd16383)    rl_n = 2'd3;
      else if (rl > 18'd127) rl_n = 2'd2;
      else                   rl_n = 2'd1;

      run_o.bytes[0] = hdr;
      for (int i = 0; i < 3; i++) begin
        if (i < int'(rl_n)) run_o.bytes[i+1] = rl_b[i];
      end
      // tail bytes start right after the remaining length field
      for (int i = 0; i < TAIL_MAX; i++) begin
        run_o.bytes[CNT_W'(i) + CNT_W'(rl_n) + CNT_W'(1)] = tail[i];
      end
      run_o.count = CNT_W'(1) + CNT_W'(rl_n) + CNT_W'(tail_n);
    end else begin
      // string data byte, then the fields that follow a closed section
      run_o.bytes[0]  = req_i.data_byte;
      st_o.bytes_left = bl_dec;
      if (bl_dec == 16'd0) begin
        case (st_i.kind)
          KIND_CONNECT: begin
            if (st_i.section == 2'd0 && st_i.held_second_len != 16'd0) begin
              run_o.bytes[1]  = st_i.held_second_len[15:8];
              run_o.bytes[2]  = st_i.held_second_len[7:0];
              run_o.count     = CNT_W'(3);
              st_o.section    = 2'd1;
              st_o.bytes_left = st_i.held_second_len;
            end else if (st_i.section != 2'd2 && st_i.held_third_len != 16'd0) begin
              run_o.bytes[1]  = st_i.held_third_len[15:8];
              run_o.bytes[2]  = st_i.held_third_len[7:0];
              run_o.count     = CNT_W'(3);
              st_o.section    = 2'd2;
              st_o.bytes_left = st_i.held_third_len;
            end else begin
              fin = 1'b1;
            end
          end
          KIND_PUBLISH: begin
            if (st_i.section == 2'd0) begin
              if (st_i.held_qos != 2'd0) begin
                run_o.bytes[1] = st_i.held_packet_ident[15:8];
                run_o.bytes[2] = st_i.held_packet_ident[7:0];
                run_o.count    = CNT_W'(3);
              end
              st_o.section    = 2'd1;
              st_o.bytes_left = st_i.held_second_len;
              if (st_i.held_second_len == 16'd0) fin = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          KIND_SUBSCRIBE: begin
            run_o.bytes[1] = {6'd0, st_i.held_qos};
            run_o.count    = CNT_W'(2);
            fin            = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
    end

    if (fin) begin
      st_o.kind       = KIND_IDLE;
      st_o.section    = 2'd0;
      st_o.bytes_left = 16'd0;
      run_o.pkt_end   = 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mqtt_control_packet_framer.sv
`default_nettype none

// Channel   Dir  Payload  Use
// req_i     in   req_t    command or string data byte requests
// res_o     out  res_t    framed wire bytes, one per transfer, or an error flag
//
// A request becomes a run of 1 to 18 result bytes; the run buffer drains one
// byte a cycle into the output register while the output is not stalled. A
// data byte gives a run of 1 byte, or up to 3 when a section closes. The next
// request is taken in the cycle the last byte of the previous run moves to
// the output register. Reset clears the packet state to idle and empties both
// stages. A stalled output holds the byte in place and back-pressures requests
// once the run buffer is non-empty.
module mqtt_control_packet_framer import mqttf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  mqttf_stream_if.sink   req_i,
  mqttf_stream_if.source res_o
);

  state_t st_q;
  state_t st_d;
  run_t   run_new;

  logic [RUN_MAX-1:0][7:0] run_bytes_q;
  logic [CNT_W-1:0]        run_cnt_q;
  logic                    run_end_q;
  logic                    run_err_q;

  logic out_valid_q;
  res_t out_q;

  logic pop;
  logic accept;
  logic in_ready;

  mqttf_step u_step (
    .st_i  (st_q),
    .req_i (req_i.payload),
    .st_o  (st_d),
    .run_o (run_new)
  );

  assign pop      = (run_cnt_q != '0) && (!out_valid_q || res_o.ready);
  assign in_ready = (run_cnt_q == '0) || ((run_cnt_q == CNT_W'(1)) && pop);
  assign accept   = req_i.valid && in_ready;

  assign req_i.ready   = in_ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.kind              <= KIND_IDLE;
      st_q.section           <= 2'd0;
      st_q.bytes_left        <= 16'd0;
      st_q.held_second_len   <= 16'd0;
      st_q.held_third_len    <= 16'd0;
      st_q.held_qos          <= 2'd0;
      st_q.held_packet_ident <= 16'd0;
      run_cnt_q              <= '0;
      out_valid_q            <= 1'b0;
    end else begin
      if (accept) begin
        st_q      <= st_d;
        run_cnt_q <= run_new.count;
      end else if (pop) begin
        run_cnt_q <= run_cnt_q - CNT_W'(1);
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_bytes_q <= run_new.bytes;
      run_end_q   <= run_new.pkt_end;
      run_err_q   <= run_new.err;
    end else if (pop) begin
      run_bytes_q <= {8'h00, run_bytes_q[RUN_MAX-1:1]};
    end
    if (pop) begin
      out_q.out_byte   <= run_bytes_q[0];
      out_q.packet_end <= run_end_q && (run_cnt_q == CNT_W'(1));
      out_q.run_last   <= (run_cnt_q == CNT_W'(1));
      out_q.seq_error  <= run_err_q;
    end
  end

endmodule

`default_nettype wire
